### hw/rtl/banked_interrupt_controller_top_macros.svh
// Assertion helpers for the checker file of the interrupt controller.
`ifndef BANKED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define BANKED_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BIC_ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BIC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/bic_pkg.sv
`default_nettype none

package bic_pkg;

  // Bank geometry.
  localparam int unsigned NumBanks  = 6;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned OffWidth  = 12;
  localparam int unsigned BankWidth = 3;
  localparam int unsigned IdxWidth  = 3;

  // Bit of the bank 6 status word that also shows the global pending summary.
  localparam int unsigned SummaryBit = 15;

  // Register map, byte offsets.
  localparam logic [OffWidth-1:0] OffStatusFirst = 12'h100;
  localparam logic [OffWidth-1:0] OffStatusLast  = 12'h110;
  localparam logic [OffWidth-1:0] OffStatus6     = 12'h114;
  localparam logic [OffWidth-1:0] OffEnableFirst = 12'h118;
  localparam logic [OffWidth-1:0] OffEnableLast  = 12'h12C;

  // Kind of an input beat.
  typedef enum logic [1:0] {
    FuncRaise = 2'd0,
    FuncRead  = 2'd1,
    FuncWrite = 2'd2
  } func_e;

  typedef logic [NumBanks-1:0][WordWidth-1:0] bank_arr_t;

  typedef struct packed {
    func_e                 func;
    logic [BankWidth-1:0]  bank;
    logic [OffWidth-1:0]   offset;
    logic [WordWidth-1:0]  data;
  } item_t;

  typedef struct packed {
    logic [WordWidth-1:0] read_data;
    logic                 hit;
    logic                 irq_normal;
    logic                 irq_high;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/banked_interrupt_controller_top.sv
// Pipeline: an accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle while in_stall_o is low; the input register and the
// result register each hold one beat, so one new beat is still taken while a result waits.
// Reset: rst_ni low clears all status and enable banks and empties both stages.
`default_nettype none

module banked_interrupt_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [2:0]  bank_i,
  input  logic [11:0] offset_i,
  input  logic [31:0] data_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        hit_o,
  output logic        irq_normal_o,
  output logic        irq_high_o
);
  import bic_pkg::*;

  logic      in_valid_q, in_valid_d;
  item_t     item_q;
  logic      out_valid_q, out_valid_d;
  result_t   result_q;
  result_t   result_d;
  bank_arr_t status_q, status_d;
  bank_arr_t enable_q, enable_d;
  logic      in_accept;
  logic      advance;

  // Handshake: the input stage moves on when it holds a beat and the result register is empty or not stalled.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.func   <= func_e'(func_i);
      item_q.bank   <= bank_i;
      item_q.offset <= offset_i;
      item_q.data   <= data_value_i;
    end
  end

  // Decode and bank update for the beat in the input register.
  bic_core u_core (
    .item_i   (item_q),
    .status_i (status_q),
    .enable_i (enable_q),
    .status_o (status_d),
    .enable_o (enable_d),
    .result_o (result_d)
  );

  // Bank state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= '0;
      enable_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        status_q <= status_d;
        enable_q <= enable_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = result_q.read_data;
  assign hit_o        = result_q.hit;
  assign irq_normal_o = result_q.irq_normal;
  assign irq_high_o   = result_q.irq_high;

endmodule

`default_nettype wire

### hw/rtl/bic_core.sv
`default_nettype none

// Decode and update logic for one beat: next bank contents and the result word.
module bic_core (
  input  bic_pkg::item_t    item_i,
  input  bic_pkg::bank_arr_t status_i,
  input  bic_pkg::bank_arr_t enable_i,
  output bic_pkg::bank_arr_t status_o,
  output bic_pkg::bank_arr_t enable_o,
  output bic_pkg::result_t  result_o
);
  import bic_pkg::*;

  logic                 is_status;
  logic                 is_status6;
  logic                 is_enable;
  logic [OffWidth-1:0]  enable_rel;
  logic [IdxWidth-1:0]  status_idx;
  logic [IdxWidth-1:0]  enable_idx;
  logic [IdxWidth-1:0]  raise_idx;
  logic                 raise_ok;
  logic [NumBanks-1:0]  pend_now;
  logic [NumBanks-1:0]  pend_next;
  logic [WordWidth-1:0] status6_word;
  logic [WordWidth-1:0] read_data;
  logic                 hit;

  // Offset decode; both windows start on a word boundary.
  assign is_status  = (item_i.offset >= OffStatusFirst) && (item_i.offset <= OffStatusLast)
                      && (item_i.offset[1:0] == 2'b00);
  assign is_status6 = (item_i.offset == OffStatus6);
  assign is_enable  = (item_i.offset >= OffEnableFirst) && (item_i.offset <= OffEnableLast)
                      && (item_i.offset[1:0] == 2'b00);
  assign enable_rel = item_i.offset - OffEnableFirst;
  assign status_idx = item_i.offset[4:2];
  assign enable_idx = enable_rel[4:2];
  assign raise_ok   = (item_i.bank >= BankWidth'(1)) && (item_i.bank <= BankWidth'(NumBanks));
  assign raise_idx  = item_i.bank - BankWidth'(1);

  // Pending flags per bank, before and after this beat.
  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      pend_now[b]  = |(status_i[b] & enable_i[b]);
      pend_next[b] = |(status_o[b] & enable_o[b]);
    end
  end

  // The bank 6 status word carries the summary of all pending banks.
  always_comb begin
    status6_word             = status_i[NumBanks-1];
    status6_word[SummaryBit] = status_i[NumBanks-1][SummaryBit] | (|pend_now);
  end

  // Bank updates and read data.
  always_comb begin
    status_o  = status_i;
    enable_o  = enable_i;
    read_data = '0;
    hit       = 1'b0;
    case (item_i.func)
      FuncRaise: begin
        if (raise_ok) begin
          status_o[raise_idx] = status_i[raise_idx] | item_i.data;
        end
      end
      FuncRead: begin
        if (is_status6) begin
          read_data = status6_word;
          hit       = 1'b1;
        end else if (is_status) begin
          read_data = status_i[status_idx];
          hit       = 1'b1;
        end else if (is_enable) begin
          read_data = enable_i[enable_idx];
          hit       = 1'b1;
        end
      end
      FuncWrite: begin
        if (is_status) begin
          status_o[status_idx] = status_i[status_idx] & ~item_i.data;
          hit                  = 1'b1;
        end else if (is_status6) begin
          hit = 1'b1;
        end else if (is_enable) begin
          enable_o[enable_idx] = item_i.data;
          hit                  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Interrupt lines reflect the banks after this beat.
  assign result_o = {read_data, hit, |pend_next[NumBanks-2:0], pend_next[NumBanks-1]};

endmodule

`default_nettype wire

### hw/rtl/bic_checker.sv
`default_nettype none
`include "banked_interrupt_controller_top_macros.svh"

// Port-level checks for the interrupt controller.
module bic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        hit_o,
  input logic        irq_normal_o,
  input logic        irq_high_o
);

  // A stalled result beat stays up.
  `BIC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result beat dropped")

  // A stalled result beat keeps its payload.
  `BIC_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i,
                   $stable(read_data_o) && $stable(hit_o) && $stable(irq_normal_o)
                   && $stable(irq_high_o), "stalled result changed")

  // Nonzero read data only comes from a decoded read.
  `BIC_ASSERT_IMPLIES(a_data_hit, out_valid_o && (read_data_o != 32'd0), hit_o,
                      "read data without a decode hit")

  // The input side only stalls behind a waiting result.
  `BIC_ASSERT_IMPLIES(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                      "input stalled with the result register free")

endmodule

bind banked_interrupt_controller_top bic_checker u_bic_checker (.*);

`default_nettype wire
